// ===== rtl/touch_sample_filter_top_defines.svh =====
// Assertion macros for the touch sample filter checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef TOUCH_SAMPLE_FILTER_TOP_DEFINES_SVH
`define TOUCH_SAMPLE_FILTER_TOP_DEFINES_SVH

// Consequence in the clock after the antecedent, ignored while in reset.
`define TSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequence in the same clock as the antecedent, ignored while in reset.
`define TSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// State that must hold in the clock after reset is sampled low.
`define TSF_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tsf_pkg.sv =====
// Shared types, sizes and codes for the touch sample filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tsf_pkg;

    localparam int WINDOW    = 5;
    localparam int COORD_W   = 16;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = COORD_W + $clog2(WINDOW);
    localparam int DEN_W     = $clog2(2 * (WINDOW - 1) + 1);
    localparam int NUM_W     = SUM_W + 1;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = (NUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int NUMP_W    = DIV_STEPS * DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int SQ_W      = 2 * COORD_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MIN_SMP_W  = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIMIT         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_LIMIT       = 2'd3;

    localparam logic [15:0]          RST_PRESSURE_THRESHOLD = 16'd1;
    localparam logic [MIN_SMP_W-1:0] RST_MIN_SAMPLES        = 7'd5;
    localparam logic [15:0]          RST_MOVE_LIMIT         = 16'd100;
    localparam logic [15:0]          RST_JITTER_LIMIT       = 16'd2;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_MOVE    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    typedef struct packed {
        logic [15:0] sample_pressure;
        logic [15:0] sample_x;
        logic [15:0] sample_y;
    } t_sample;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] point_x;
        logic [15:0] point_y;
    } t_event;

    typedef struct packed {
        logic capture;
        logic load;
        logic prep;
        logic div_step;
        logic square;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic average;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/touch_sample_filter_top.sv =====
// Top level of the touch sample filter: sequencer plus datapath.
// Depends on tsf_pkg, tsf_ctrl and tsf_datapath.
`timescale 1ns / 1ps

// Filters raw touch samples into press, move and release events. One item is
// worked on at a time: a sample that lifts the pen or is still filling the
// history goes from load straight to commit; a sample that is averaged
// also passes through prep, the divide steps and square, where the divider
// forming the rounded x and y means yields four quotient bits per cycle.
// An event sits in an output register; the next sample is accepted while it
// waits, and an item only holds in its final cycle if the previous event has
// still not been taken.
// Configuration registers may be written only while no item is in flight.
module touch_sample_filter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tsf_pkg::t_sample                 i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tsf_pkg::t_event                  o_out_item,
    input  logic                             i_cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tsf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    tsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tsf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_sample    (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/tsf_ctrl.sv =====
// Sequencer of the touch sample filter: one item at a time through
// load, prep, divide, square and commit. Depends on tsf_pkg.
`timescale 1ns / 1ps

module tsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tsf_pkg::t_stat i_stat,
    output tsf_pkg::t_cmd  o_cmd
);
    import tsf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_PREP   = 6'b000100,
        S_DIV    = 6'b001000,
        S_SQUARE = 6'b010000,
        S_COMMIT = 6'b100000
    } t_state;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                // release and fill-up items need no mean
                n_state = i_stat.average ? S_PREP : S_COMMIT;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_div_cnt  = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the output register can take a result
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/tsf_datapath.sv =====
// Datapath of the touch sample filter: configuration, point ring, running
// sums, radix-16 mean divider, step squares and output register. Uses tsf_pkg.
`timescale 1ns / 1ps

module tsf_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tsf_pkg::t_cmd                    i_cmd,
    output tsf_pkg::t_stat                   o_stat,
    input  tsf_pkg::t_sample                 i_sample,
    input  logic                             i_cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tsf_pkg::t_event                  o_out_item
);
    import tsf_pkg::*;

    // one radix-16 step of restoring division by a small divisor
    function automatic logic [DEN_W+DIV_BITS-1:0] div_digits(
        input logic [DEN_W-1:0]    rem,
        input logic [DIV_BITS-1:0] bits,
        input logic [DEN_W-1:0]    den
    );
        logic [DEN_W:0]      t;
        logic [DEN_W-1:0]    r;
        logic [DIV_BITS-1:0] q;
        r = rem;
        q = '0;
        for (int k = DIV_BITS - 1; k >= 0; k--) begin
            t = {r, bits[k]};
            if (t >= {1'b0, den}) begin
                t    = t - {1'b0, den};
                q[k] = 1'b1;
            end
            r = t[DEN_W-1:0];
        end
        return {r, q};
    endfunction

    // configuration registers
    logic [15:0]          r_pressure_threshold, r_move_limit, r_jitter_limit;
    logic [MIN_SMP_W-1:0] r_min_samples;
    logic [SQ_W-1:0]      r_move_sq, r_jit_sq;

    // filter state
    logic [COORD_W-1:0]   r_ring_x [WINDOW];
    logic [COORD_W-1:0]   r_ring_y [WINDOW];
    logic [SLOT_W-1:0]    r_ws, r_os;
    logic [CNT_W-1:0]     r_count;
    logic [SUM_W-1:0]     r_sum_x, r_sum_y;
    logic [COORD_W-1:0]   r_rep_x, r_rep_y;
    logic                 r_pen;
    logic [1:0]           r_skip;

    // per-item working registers
    t_sample              r_sample;
    logic                 r_touch, r_short, r_nw;
    logic [CNT_W-1:0]     r_n;
    logic [SUM_W-1:0]     r_tx, r_ty;
    logic [DEN_W-1:0]     r_d, r_den;
    logic [NUMP_W-1:0]    r_num_x, r_num_y;
    logic [DEN_W-1:0]     r_rem_x, r_rem_y;
    logic [COORD_W-1:0]   r_quo_x, r_quo_y;
    logic [SQ_W-1:0]      r_dsq_x, r_dsq_y;

    logic                 r_out_valid;
    t_event               r_out_item;

    logic                 w_touch, w_nw, w_short;
    logic [CNT_W-1:0]     w_n, w_need;
    logic [COORD_W-1:0]   w_old_x, w_old_y;
    logic [SUM_W-1:0]     w_tx, w_ty;
    logic [DEN_W-1:0]     w_d;
    logic [NUM_W-1:0]     w_num_x, w_num_y;
    logic [DEN_W+DIV_BITS-1:0] w_div_x, w_div_y;
    logic [COORD_W-1:0]   w_dx, w_dy;
    logic [SQ_W:0]        w_step;
    logic                 w_reject, w_bump, w_pop;
    logic                 w_emit_rel, w_emit_press, w_emit_move, w_advance;
    logic [SLOT_W-1:0]    w_ws_next, w_os_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressure_threshold <= RST_PRESSURE_THRESHOLD;
            r_min_samples        <= RST_MIN_SAMPLES;
            r_move_limit         <= RST_MOVE_LIMIT;
            r_jitter_limit       <= RST_JITTER_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRESSURE_THRESHOLD: r_pressure_threshold <= i_cfg_data;
                CFG_MIN_SAMPLES:        r_min_samples <= i_cfg_data[MIN_SMP_W-1:0];
                CFG_MOVE_LIMIT:         r_move_limit <= i_cfg_data;
                CFG_JITTER_LIMIT:       r_jitter_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // limit squares track the registers; only read long after a write
    always_ff @(posedge i_clk) begin
        r_move_sq <= r_move_limit * r_move_limit;
        r_jit_sq  <= r_jitter_limit * r_jitter_limit;
    end

    // load: classify the item and form the window totals
    assign w_touch = (r_sample.sample_pressure >= r_pressure_threshold);
    assign w_n     = (r_count >= CNT_W'(WINDOW)) ? CNT_W'(WINDOW) : r_count + 1'b1;
    assign w_need  = (r_min_samples > MIN_SMP_W'(WINDOW)) ? CNT_W'(WINDOW)
                                                          : r_min_samples[CNT_W-1:0];
    assign w_short = (w_n < w_need);
    assign w_nw    = (w_n == CNT_W'(WINDOW));
    assign w_old_x = w_nw ? r_ring_x[r_os] : '0;
    assign w_old_y = w_nw ? r_ring_y[r_os] : '0;
    assign w_tx    = r_sum_x + SUM_W'(r_sample.sample_x) - SUM_W'(w_old_x);
    assign w_ty    = r_sum_y + SUM_W'(r_sample.sample_y) - SUM_W'(w_old_y);
    assign w_d     = (w_n < CNT_W'(WINDOW - 1)) ? DEN_W'(w_n) : DEN_W'(WINDOW - 1);

    assign o_stat.average  = w_touch && !w_short;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // rounding half up: (2t + d) / (2d)
    assign w_num_x = {r_tx, 1'b0} + NUM_W'(r_d);
    assign w_num_y = {r_ty, 1'b0} + NUM_W'(r_d);
    assign w_div_x = div_digits(r_rem_x, r_num_x[NUMP_W-1 -: DIV_BITS], r_den);
    assign w_div_y = div_digits(r_rem_y, r_num_y[NUMP_W-1 -: DIV_BITS], r_den);

    assign w_dx = (r_quo_x > r_rep_x) ? r_quo_x - r_rep_x : r_rep_x - r_quo_x;
    assign w_dy = (r_quo_y > r_rep_y) ? r_quo_y - r_rep_y : r_rep_y - r_quo_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.load) begin
            r_touch <= w_touch;
            r_short <= w_short;
            r_nw    <= w_nw;
            r_n     <= w_n;
            r_tx    <= w_tx;
            r_ty    <= w_ty;
            r_d     <= w_d;
            // every touching item lands in the ring, even if later rejected
            if (w_touch) begin
                r_ring_x[r_ws] <= r_sample.sample_x;
                r_ring_y[r_ws] <= r_sample.sample_y;
            end
        end
        if (i_cmd.prep) begin
            r_num_x <= NUMP_W'(w_num_x);
            r_num_y <= NUMP_W'(w_num_y);
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_den   <= {r_d[DEN_W-2:0], 1'b0};
        end
        if (i_cmd.div_step) begin
            r_num_x <= {r_num_x[NUMP_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
            r_num_y <= {r_num_y[NUMP_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
            r_rem_x <= w_div_x[DEN_W+DIV_BITS-1 -: DEN_W];
            r_rem_y <= w_div_y[DEN_W+DIV_BITS-1 -: DEN_W];
            r_quo_x <= {r_quo_x[COORD_W-DIV_BITS-1:0], w_div_x[DIV_BITS-1:0]};
            r_quo_y <= {r_quo_y[COORD_W-DIV_BITS-1:0], w_div_y[DIV_BITS-1:0]};
        end
        if (i_cmd.square) begin
            r_dsq_x <= w_dx * w_dx;
            r_dsq_y <= w_dy * w_dy;
        end
    end

    // commit: accept or reject the mean and pick the event
    assign w_step    = r_pen ? ({1'b0, r_dsq_x} + {1'b0, r_dsq_y}) : '0;
    assign w_reject  = (w_step >= {1'b0, r_move_sq});
    assign w_bump    = (w_step > {1'b0, r_jit_sq}) || (r_skip > 2'd2);
    assign w_advance = i_cmd.commit && r_touch && !r_short && !w_reject;
    assign w_emit_rel   = i_cmd.commit && !r_touch && r_pen;
    assign w_emit_press = w_advance && !r_pen;
    assign w_emit_move  = w_advance && r_pen && w_bump;
    assign w_ws_next = (r_ws == SLOT_W'(WINDOW - 1)) ? '0 : r_ws + 1'b1;
    assign w_os_next = (r_os == SLOT_W'(WINDOW - 1)) ? '0 : r_os + 1'b1;
    assign w_pop     = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= '0;
            r_os        <= '0;
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_rep_x     <= '0;
            r_rep_y     <= '0;
            r_pen       <= 1'b0;
            r_skip      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit_rel || w_emit_press || w_emit_move) begin
                r_out_valid <= 1'b1;
            end else if (w_pop) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit && !r_touch) begin
                // pen lifted: drop all history
                r_ws    <= '0;
                r_os    <= '0;
                r_count <= '0;
                r_skip  <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_pen   <= 1'b0;
            end
            if (i_cmd.commit && r_touch && r_short) begin
                r_sum_x <= r_tx;
                r_sum_y <= r_ty;
                r_count <= r_n;
                r_ws    <= w_ws_next;
            end
            if (w_advance) begin
                r_sum_x <= r_tx;
                r_sum_y <= r_ty;
                r_count <= r_n;
                r_ws    <= w_ws_next;
                if (r_nw) begin
                    r_os <= w_os_next;
                end
                if (w_emit_press || w_emit_move) begin
                    r_rep_x <= r_quo_x;
                    r_rep_y <= r_quo_y;
                    r_skip  <= '0;
                    r_pen   <= 1'b1;
                end else begin
                    r_skip <= r_skip + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_rel) begin
            r_out_item.event_kind <= KIND_RELEASE;
            r_out_item.point_x    <= r_rep_x;
            r_out_item.point_y    <= r_rep_y;
        end else if (w_emit_press || w_emit_move) begin
            r_out_item.event_kind <= w_emit_press ? KIND_PRESS : KIND_MOVE;
            r_out_item.point_x    <= r_quo_x;
            r_out_item.point_y    <= r_quo_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/tsf_checker.sv =====
// Port-level checks for the touch sample filter, bound to the top level.
// Depends on tsf_pkg and touch_sample_filter_top_defines.svh.
`timescale 1ns / 1ps
`include "touch_sample_filter_top_defines.svh"

module tsf_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_stall,
    input logic            i_out_valid,
    input logic            i_out_stall,
    input tsf_pkg::t_event i_out_item
);
    import tsf_pkg::*;

    // one item at a time: acceptance closes the input side
    `TSF_ASSERT_NEXT(a_accept_closes, i_in_valid && !i_in_stall, i_in_stall, "tsf: input open while busy")

    `TSF_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_item), "tsf: stalled event changed")

    `TSF_ASSERT_NOW(a_kind_legal, i_out_valid, (i_out_item.event_kind == KIND_PRESS) || (i_out_item.event_kind == KIND_MOVE) || (i_out_item.event_kind == KIND_RELEASE), "tsf: bad event kind")

    // a fresh event only appears as an item finishes
    `TSF_ASSERT_NOW(a_event_from_item, $rose(i_out_valid), $past(i_in_stall), "tsf: event without item")

    `TSF_ASSERT_RESET(a_reset_idle, !i_out_valid && !i_in_stall, "tsf: not idle after reset")

endmodule

bind touch_sample_filter_top tsf_checker u_tsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
